@@ hw/rtl/stable_priority_stack_assert.svh @@
// Assertion macros used by the checker file of the priority stack.
`ifndef STABLE_PRIORITY_STACK_ASSERT_SVH
`define STABLE_PRIORITY_STACK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/sps_pkg.sv @@
package sps_pkg;

    localparam int CAPACITY   = 16;
    localparam int ELEM_BITS  = 32;
    localparam int PRIO_BITS  = 8;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int MODE_BITS  = 2;

    localparam logic [MODE_BITS-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_POP   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_QUERY = 2'd2;

    typedef logic [ELEM_BITS-1:0]  elem_t;
    typedef logic [PRIO_BITS-1:0]  prio_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic  push;
        logic  pop;
        elem_t elem;
        prio_t prio;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/stable_priority_stack.sv @@
// Bounded priority stack built as a row of compare-and-shift cells, head in
// the first cell. On each request all cells compare the pushed priority with
// their own in parallel and either hold, load the new pair, or shift one
// place toward the tail (push) or toward the head (pop). A result register
// holds one response, and a new request is accepted in the same cycle that
// the waiting response is taken, so the block sustains one request per clock
// while responses are taken.
module stable_priority_stack (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [sps_pkg::MODE_BITS-1:0] s_mode,
    input  sps_pkg::elem_t            s_elem,
    input  sps_pkg::prio_t            s_prio,
    output logic                      m_valid,
    input  logic                      m_ready,
    output sps_pkg::elem_t            m_head_elem,
    output sps_pkg::prio_t            m_head_prio,
    output sps_pkg::count_t           m_count,
    output logic                      m_is_empty,
    output sps_pkg::elem_t            m_taken_elem,
    output sps_pkg::prio_t            m_taken_prio,
    output logic                      m_error
);

    sps_pkg::count_t     count_reg, count_next;
    logic                m_valid_reg;
    sps_pkg::elem_t      head_elem_reg, taken_elem_reg;
    sps_pkg::prio_t      head_prio_reg, taken_prio_reg;
    sps_pkg::count_t     count_out_reg;
    logic                is_empty_reg, error_reg;

    logic                accept, full, empty, push_ok, pop_ok, bad;
    sps_pkg::cell_ctrl_t ctrl;

    sps_pkg::elem_t      cell_elem      [sps_pkg::CAPACITY];
    sps_pkg::prio_t      cell_prio      [sps_pkg::CAPACITY];
    logic                cell_keep      [sps_pkg::CAPACITY];
    sps_pkg::elem_t      cell_elem_next [sps_pkg::CAPACITY];
    sps_pkg::prio_t      cell_prio_next [sps_pkg::CAPACITY];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == sps_pkg::COUNT_BITS'(sps_pkg::CAPACITY));
    assign empty   = (count_reg == '0);
    assign push_ok = accept && (s_mode == sps_pkg::MODE_PUSH) && !full;
    assign pop_ok  = accept && (s_mode == sps_pkg::MODE_POP) && !empty;
    assign bad     = ((s_mode == sps_pkg::MODE_PUSH) && full) ||
                     ((s_mode == sps_pkg::MODE_POP) && empty);

    assign ctrl.push = push_ok;
    assign ctrl.pop  = pop_ok;
    assign ctrl.elem = s_elem;
    assign ctrl.prio = s_prio;

    always_comb begin
        count_next = count_reg;
        if (push_ok) begin
            count_next = count_reg + 1'b1;
        end else if (pop_ok) begin
            count_next = count_reg - 1'b1;
        end
    end

    for (genvar i = 0; i < sps_pkg::CAPACITY; i++) begin : g_cell
        sps_pkg::elem_t lft_elem, rgt_elem;
        sps_pkg::prio_t lft_prio, rgt_prio;
        logic           lft_keep;

        if (i == 0) begin : g_first
            assign lft_elem = '0;
            assign lft_prio = '0;
            assign lft_keep = 1'b1;
        end else begin : g_mid
            assign lft_elem = cell_elem[i-1];
            assign lft_prio = cell_prio[i-1];
            assign lft_keep = cell_keep[i-1];
        end

        if (i == sps_pkg::CAPACITY - 1) begin : g_last
            assign rgt_elem = '0;
            assign rgt_prio = '0;
        end else begin : g_inner
            assign rgt_elem = cell_elem[i+1];
            assign rgt_prio = cell_prio[i+1];
        end

        sps_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .occ        (sps_pkg::COUNT_BITS'(i) < count_reg),
            .left_elem  (lft_elem),
            .left_prio  (lft_prio),
            .left_keep  (lft_keep),
            .right_elem (rgt_elem),
            .right_prio (rgt_prio),
            .elem       (cell_elem[i]),
            .prio       (cell_prio[i]),
            .keep       (cell_keep[i]),
            .elem_next  (cell_elem_next[i]),
            .prio_next  (cell_prio_next[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            head_elem_reg  <= (count_next != '0) ? cell_elem_next[0] : '0;
            head_prio_reg  <= (count_next != '0) ? cell_prio_next[0] : '0;
            count_out_reg  <= count_next;
            is_empty_reg   <= (count_next == '0);
            taken_elem_reg <= pop_ok ? cell_elem[0] : '0;
            taken_prio_reg <= pop_ok ? cell_prio[0] : '0;
            error_reg      <= bad;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_head_elem  = head_elem_reg;
    assign m_head_prio  = head_prio_reg;
    assign m_count      = count_out_reg;
    assign m_is_empty   = is_empty_reg;
    assign m_taken_elem = taken_elem_reg;
    assign m_taken_prio = taken_prio_reg;
    assign m_error      = error_reg;

endmodule

@@ hw/rtl/sps_cell.sv @@
module sps_cell (
    input  logic                aclk,
    input  sps_pkg::cell_ctrl_t ctrl,
    input  logic                occ,
    input  sps_pkg::elem_t      left_elem,
    input  sps_pkg::prio_t      left_prio,
    input  logic                left_keep,
    input  sps_pkg::elem_t      right_elem,
    input  sps_pkg::prio_t      right_prio,
    output sps_pkg::elem_t      elem,
    output sps_pkg::prio_t      prio,
    output logic                keep,
    output sps_pkg::elem_t      elem_next,
    output sps_pkg::prio_t      prio_next
);

    sps_pkg::elem_t elem_reg;
    sps_pkg::prio_t prio_reg;

    // An occupied cell of strictly higher priority stays in place on a push.
    assign keep = occ && (prio_reg > ctrl.prio);

    always_comb begin
        elem_next = elem_reg;
        prio_next = prio_reg;
        if (ctrl.push) begin
            if (!keep) begin
                if (left_keep) begin
                    elem_next = ctrl.elem;
                    prio_next = ctrl.prio;
                end else begin
                    elem_next = left_elem;
                    prio_next = left_prio;
                end
            end
        end else if (ctrl.pop) begin
            elem_next = right_elem;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge aclk) begin
        elem_reg <= elem_next;
        prio_reg <= prio_next;
    end

    assign elem = elem_reg;
    assign prio = prio_reg;

endmodule

@@ hw/rtl/sps_checker.sv @@
`include "stable_priority_stack_assert.svh"

module sps_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [sps_pkg::MODE_BITS-1:0] s_mode,
    input sps_pkg::elem_t                s_elem,
    input sps_pkg::prio_t                s_prio,
    input logic                          m_valid,
    input logic                          m_ready,
    input sps_pkg::elem_t                m_head_elem,
    input sps_pkg::prio_t                m_head_prio,
    input sps_pkg::count_t               m_count,
    input logic                          m_is_empty,
    input sps_pkg::elem_t                m_taken_elem,
    input sps_pkg::prio_t                m_taken_prio,
    input logic                          m_error
);

    // An empty store reports a zero head and zero count.
    `SPS_ASSERT_SAME(a_empty_head, m_valid && m_is_empty, (m_count == '0) && (m_head_elem == '0) && (m_head_prio == '0), "empty result with nonzero head or count")

    // A failed request removes nothing.
    `SPS_ASSERT_SAME(a_error_taken, m_valid && m_error, (m_taken_elem == '0) && (m_taken_prio == '0), "failed request reports a removed pair")

    // The count never exceeds the capacity.
    `SPS_ASSERT_SAME(a_count_range, m_valid, m_count <= sps_pkg::COUNT_BITS'(sps_pkg::CAPACITY), "count above capacity")

    // A stalled response holds.
    `SPS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_count) && $stable(m_head_elem), "stalled response changed")

endmodule

bind stable_priority_stack sps_checker u_sps_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam logic [sps_pkg::MODE_BITS-1:0] MODE_SPARE = 2'd3;
    localparam int MAX_GAP = 18;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_START = 300;

    typedef struct {
        logic [sps_pkg::MODE_BITS-1:0] mode;
        sps_pkg::elem_t                elem;
        sps_pkg::prio_t                prio;
        int                            gap;
    } stack_request_t;

    typedef struct {
        sps_pkg::elem_t  head_elem;
        sps_pkg::prio_t  head_prio;
        sps_pkg::count_t count;
        logic            is_empty;
        sps_pkg::elem_t  taken_elem;
        sps_pkg::prio_t  taken_prio;
        logic            error;
    } stack_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [sps_pkg::MODE_BITS-1:0] s_mode = sps_pkg::MODE_QUERY;
    sps_pkg::elem_t                s_elem = '0;
    sps_pkg::prio_t                s_prio = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    sps_pkg::elem_t                m_head_elem;
    sps_pkg::prio_t                m_head_prio;
    sps_pkg::count_t               m_count;
    logic                          m_is_empty;
    sps_pkg::elem_t                m_taken_elem;
    sps_pkg::prio_t                m_taken_prio;
    logic                          m_error;

    stack_request_t pending_requests[$];
    stack_result_t  expected_results[$];

    sps_pkg::elem_t stored_elem[sps_pkg::CAPACITY];
    sps_pkg::prio_t stored_prio[sps_pkg::CAPACITY];
    int             stored_count = 0;

    int request_total = 0;
    int accepted_count = 0;
    int mismatch_count = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit recv_steady = 1'b0;

    stable_priority_stack uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_elem       (s_elem),
        .s_prio       (s_prio),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_head_elem  (m_head_elem),
        .m_head_prio  (m_head_prio),
        .m_count      (m_count),
        .m_is_empty   (m_is_empty),
        .m_taken_elem (m_taken_elem),
        .m_taken_prio (m_taken_prio),
        .m_error      (m_error)
    );

    always #10 aclk = ~aclk;

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #5000000;
        $display("** stable_priority_stack: FAILED **");
        $finish;
    end

    // Applies one request to the local copy of the store and returns the response.
    function automatic stack_result_t apply_request(logic [sps_pkg::MODE_BITS-1:0] mode,
                                                    sps_pkg::elem_t elem,
                                                    sps_pkg::prio_t prio);
        stack_result_t r;
        int pos;
        r = '{default: '0};
        if (mode == sps_pkg::MODE_PUSH) begin
            if (stored_count >= sps_pkg::CAPACITY) begin
                r.error = 1'b1;
            end else begin
                pos = 0;
                while (pos < stored_count && stored_prio[pos] > prio) pos++;
                for (int i = stored_count; i > pos; i--) begin
                    stored_elem[i] = stored_elem[i-1];
                    stored_prio[i] = stored_prio[i-1];
                end
                stored_elem[pos] = elem;
                stored_prio[pos] = prio;
                stored_count++;
            end
        end else if (mode == sps_pkg::MODE_POP) begin
            if (stored_count == 0) begin
                r.error = 1'b1;
            end else begin
                r.taken_elem = stored_elem[0];
                r.taken_prio = stored_prio[0];
                for (int i = 1; i < stored_count; i++) begin
                    stored_elem[i-1] = stored_elem[i];
                    stored_prio[i-1] = stored_prio[i];
                end
                stored_count--;
            end
        end
        if (stored_count > 0) begin
            r.head_elem = stored_elem[0];
            r.head_prio = stored_prio[0];
        end
        r.count = sps_pkg::count_t'(stored_count);
        r.is_empty = (stored_count == 0);
        return r;
    endfunction

    task automatic add_request(logic [sps_pkg::MODE_BITS-1:0] mode, sps_pkg::elem_t elem,
                               sps_pkg::prio_t prio, int gap);
        stack_request_t req;
        req.mode = mode;
        req.elem = elem;
        req.prio = prio;
        req.gap = gap;
        pending_requests.push_back(req);
        request_total++;
    endtask

    task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
        if (expv !== actv) begin
            if (mismatch_count < 10) begin
                $display("Mismatch in %s at %0t: expected %h, got %h", name, $realtime,
                         expv, actv);
            end
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : driver
        stack_request_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(apply_request(s_mode, s_elem, s_prio));
                accepted_count <= accepted_count + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (pending_requests[0].gap > 0) begin
                    pending_requests[0].gap = pending_requests[0].gap - 1;
                    s_valid <= 1'b0;
                end else begin
                    req = pending_requests.pop_front();
                    s_valid <= 1'b1;
                    s_mode <= req.mode;
                    s_elem <= req.elem;
                    s_prio <= req.prio;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && accepted_count >= HOLD_START) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin : monitor
        stack_result_t exp_r;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("Unexpected response at %0t", $realtime);
                    end
                    mismatch_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("head_elem", exp_r.head_elem, m_head_elem);
                    check_field("head_prio", exp_r.head_prio, m_head_prio);
                    check_field("count", exp_r.count, m_count);
                    check_field("is_empty", exp_r.is_empty, m_is_empty);
                    check_field("taken_elem", exp_r.taken_elem, m_taken_elem);
                    check_field("taken_prio", exp_r.taken_prio, m_taken_prio);
                    check_field("error", exp_r.error, m_error);
                end
                if ($urandom_range(0, 39) == 0) recv_steady = ~recv_steady;
                stall_left = recv_steady ? 0 : int'($urandom_range(0, MAX_GAP));
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
            end
            m_ready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    initial begin : stimulus
        int bias;
        int bias_left;
        int pick;
        bit steady;
        logic [sps_pkg::MODE_BITS-1:0] mode;
        sps_pkg::prio_t prio;
        int gap;

        // Requests on an empty store, including the unused mode code.
        add_request(sps_pkg::MODE_QUERY, 32'h1234_5678, 8'h12, 0);
        add_request(sps_pkg::MODE_POP, 32'hFFFF_FFFF, 8'hFF, 3);
        add_request(MODE_SPARE, 32'hDEAD_BEEF, 8'h55, 0);
        // Field extremes; equal priorities must leave last in, first out.
        add_request(sps_pkg::MODE_PUSH, 32'h0000_0000, 8'h00, 0);
        add_request(sps_pkg::MODE_PUSH, 32'hFFFF_FFFF, 8'hFF, 1);
        add_request(sps_pkg::MODE_PUSH, 32'hA5A5_5A5A, 8'hFF, 0);
        add_request(sps_pkg::MODE_POP, 32'h0, 8'h0, 0);
        add_request(sps_pkg::MODE_POP, 32'h0, 8'h0, 2);
        // Fill to capacity with mixed and repeated priorities, then overflow.
        for (int i = 0; i < 15; i++) begin
            add_request(sps_pkg::MODE_PUSH, $urandom,
                        sps_pkg::prio_t'((i * 37) % 5 * 60), i % 3);
        end
        add_request(sps_pkg::MODE_PUSH, 32'h5555_AAAA, 8'h80, 0);
        add_request(sps_pkg::MODE_QUERY, 32'h0, 8'h0, 0);

        bias = 0;
        bias_left = 0;
        steady = 1'b0;
        for (int n = 0; n < 750; n++) begin
            if (bias_left == 0) begin
                bias = $urandom_range(0, 2);
                bias_left = $urandom_range(10, 50);
            end
            bias_left--;
            pick = $urandom_range(0, 99);
            case (bias)
                0: mode = pick < 75 ? sps_pkg::MODE_PUSH : pick < 93 ? sps_pkg::MODE_POP
                        : pick < 98 ? sps_pkg::MODE_QUERY : MODE_SPARE;
                1: mode = pick < 20 ? sps_pkg::MODE_PUSH : pick < 93 ? sps_pkg::MODE_POP
                        : pick < 98 ? sps_pkg::MODE_QUERY : MODE_SPARE;
                default: mode = pick < 45 ? sps_pkg::MODE_PUSH
                        : pick < 90 ? sps_pkg::MODE_POP
                        : pick < 97 ? sps_pkg::MODE_QUERY : MODE_SPARE;
            endcase
            case ($urandom_range(0, 3))
                0: prio = sps_pkg::prio_t'($urandom_range(0, 3));
                1: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: prio = sps_pkg::prio_t'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 29) == 0) steady = ~steady;
            gap = steady ? 0 : int'($urandom_range(0, MAX_GAP));
            // Keep the sender busy around the receiver's long hold-off.
            if (request_total >= HOLD_START - 10 && request_total < HOLD_START + 60) gap = 0;
            add_request(mode, $urandom, prio, gap);
        end

        while (accepted_count != request_total || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("** stable_priority_stack: PASSED **");
        end else begin
            $display("** stable_priority_stack: FAILED **");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/sps_pkg.sv
hw/rtl/sps_cell.sv
hw/rtl/stable_priority_stack.sv
hw/rtl/sps_checker.sv
sim/testbench.sv
